// ===== rtl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the transposition table engine: transaction
// payloads, the stored way layout, opcodes and controller states.
// ----------------------------------------------------------------------------
package tte_pkg;

  // defaults of the top level parameters
  localparam int NUM_WAYS_DEF    = 4;
  localparam int NUM_BUCKETS_DEF = 1024;

  // hash field width and fraction bits of the bucket reciprocal
  localparam int HASH_W    = 10;
  localparam int HASH_FRAC = 20;

  localparam logic [15:0] GEN_FIRST = 16'd1;
  localparam logic [15:0] GEN_LAST  = 16'hFFFF;
  localparam logic [7:0]  DEPTH_MAX = 8'd255;

  // bound kinds, low two bits of the bound byte
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;
  localparam logic [1:0] KIND_EXACT = 2'd3;

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_NEW_SEARCH = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [63:0]         key_low;
    logic [63:0]         key_high;
    logic [HASH_W-1:0]   hash_index;
    logic [7:0]          entry_tag;
    logic signed [15:0]  window_alpha;
    logic signed [15:0]  window_beta;
    logic signed [15:0]  store_value;
    logic [15:0]         store_move;
    logic signed [15:0]  store_depth;
    logic [7:0]          store_bound;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic                partial;
    logic signed [15:0]  found_value;
    logic [15:0]         found_move;
    logic [7:0]          found_depth;
    logic [7:0]          found_bound;
    logic                evicted;
  } out_item_t;

  // one way of a bucket row; generation zero marks a dead way
  typedef struct packed {
    logic [63:0]         key_high;
    logic [63:0]         key_low;
    logic [15:0]         move;
    logic [7:0]          tag;
    logic [7:0]          bound;
    logic [7:0]          depth;
    logic [15:0]         gen;
    logic signed [15:0]  value;
  } way_t;

endpackage

// ===== rtl/transposition_table_engine.sv =====
// ----------------------------------------------------------------------------
// transposition_table_engine
// Set-associative transposition table with generation aging, one bucket row
// per memory word, one row read per transaction and written back on an enabled store.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall / in_data, one transaction per operation
//   (probe, store, new search, clear). out channel: out_valid / out_stall /
//   out_data, exactly one result transaction per input transaction.
//   cfg_write / cfg_data set the table enable bit; write only while idle.
// transaction steps
//   the bucket row is read from the table memory and checked; an enabled
//   store writes it back. with a power-of-two bucket count (or 1024 and
//   more) a transaction is accepted, then looked up and, on a store,
//   written back with the result registered. other bucket counts add the
//   S_ADDR state for the modulo (reciprocal multiply, then multiply-subtract)
//   in between. a new transaction is accepted only once the last one is done.
// reset and wipe
//   reset, clear and the new search that wraps the generation run a sweep
//   that zeroes every row, one row per cycle; in_stall stays high
//   meanwhile. config writes are taken as ever.
// output stall
//   a finished result waits in the output register while the next
//   transaction is accepted; the lookup holds until that register is free.
// ----------------------------------------------------------------------------
module transposition_table_engine #(
  parameter int NUM_WAYS    = tte_pkg::NUM_WAYS_DEF,
  parameter int NUM_BUCKETS = tte_pkg::NUM_BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  tte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tte_pkg::out_item_t out_data
);

  localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int HASH_W  = tte_pkg::HASH_W;
  localparam int FRAC    = tte_pkg::HASH_FRAC;
  localparam int RECIP_W = FRAC + 1;
  localparam int QPROD_W = HASH_W + RECIP_W;
  localparam int RPROD_W = 2 * HASH_W;
  // bucket taken straight from the hash bits when no modulo is needed
  localparam bit DIRECT  = (NUM_BUCKETS >= (1 << HASH_W)) ||
                           ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  // ceil(2^FRAC / N) gives the exact quotient for any hash value
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << FRAC) + NUM_BUCKETS - 1) / NUM_BUCKETS);
  localparam logic [HASH_W-1:0] NB_SMALL = HASH_W'(NUM_BUCKETS);
  localparam logic [BKT_W-1:0]  LAST_ROW = BKT_W'(NUM_BUCKETS - 1);

  // table memory, one bucket row per word
  tte_pkg::way_t [NUM_WAYS-1:0] bucket_mem [NUM_BUCKETS];
  tte_pkg::way_t [NUM_WAYS-1:0] rd_row;
  tte_pkg::way_t [NUM_WAYS-1:0] new_row;
  tte_pkg::way_t [NUM_WAYS-1:0] mem_wdata;
  logic [BKT_W-1:0]             mem_waddr;
  logic                         mem_we;
  logic [BKT_W-1:0]             rd_addr;

  tte_pkg::state_t   state;
  tte_pkg::state_t   state_next;
  tte_pkg::in_item_t item;
  logic [BKT_W-1:0]  bucket;
  logic [HASH_W-1:0] quot;
  logic [15:0]       cur_gen;
  logic              enabled;
  logic [BKT_W-1:0]  clr_idx;

  logic               accept;
  logic               finish;
  logic               store_we;
  logic               wipe;
  tte_pkg::out_item_t res;

  // bucket selection
  logic [QPROD_W-1:0] quot_prod;
  logic [RPROD_W-1:0] rem_prod;
  logic [HASH_W-1:0]  rem_val;
  logic [BKT_W-1:0]   direct_bucket;

  assign quot_prod = QPROD_W'(in_data.hash_index) * QPROD_W'(RECIP);
  assign rem_prod  = RPROD_W'(quot) * RPROD_W'(NB_SMALL);
  assign rem_val   = item.hash_index - rem_prod[HASH_W-1:0];
  assign direct_bucket = (NUM_BUCKETS == 1) ? '0 : BKT_W'(in_data.hash_index);

  always_comb begin
    case (state)
      tte_pkg::S_IDLE: rd_addr = DIRECT ? direct_bucket : '0;
      tte_pkg::S_ADDR: rd_addr = BKT_W'(rem_val);
      default:         rd_addr = bucket;
    endcase
  end

  assign accept   = (state == tte_pkg::S_IDLE) && in_valid;
  assign in_stall = (state != tte_pkg::S_IDLE);
  assign finish   = (state == tte_pkg::S_LOOKUP) && (!out_valid || !out_stall);

  // per-way match and replacement score
  logic [NUM_WAYS-1:0] live;
  logic [NUM_WAYS-1:0] key_eq;
  logic [NUM_WAYS-1:0] probe_m;
  logic [NUM_WAYS-1:0] store_m;
  logic [NUM_WAYS-1:0] is_min;
  logic [8:0]          score [NUM_WAYS];

  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      live[i]   = (rd_row[i].gen == cur_gen);
      key_eq[i] = (rd_row[i].key_low == item.key_low) &&
                  (rd_row[i].key_high == item.key_high);
      probe_m[i] = live[i] && key_eq[i] && (rd_row[i].tag == item.entry_tag);
      store_m[i] = live[i] && key_eq[i];
      score[i]   = live[i] ? (9'(rd_row[i].depth) + 9'd1) : 9'd0;
    end
    // earliest way with the lowest score, by pairwise compares
    for (int i = 0; i < NUM_WAYS; i++) begin
      is_min[i] = 1'b1;
      for (int j = 0; j < NUM_WAYS; j++) begin
        if (j < i && !(score[i] < score[j])) is_min[i] = 1'b0;
        if (j > i && !(score[i] <= score[j])) is_min[i] = 1'b0;
      end
    end
  end

  logic [WAY_W-1:0] p_idx;
  logic [WAY_W-1:0] s_idx;
  logic [WAY_W-1:0] m_idx;
  logic [WAY_W-1:0] victim;
  logic             p_found;
  logic             s_found;

  always_comb begin
    p_idx = '0;
    s_idx = '0;
    m_idx = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (probe_m[i]) p_idx = WAY_W'(i);
      if (store_m[i]) s_idx = WAY_W'(i);
      if (is_min[i])  m_idx = WAY_W'(i);
    end
    p_found = |probe_m;
    s_found = |store_m;
    victim  = s_found ? s_idx : m_idx;
  end

  // operation result and write-back row
  tte_pkg::way_t      p_way;
  tte_pkg::way_t      w_way;
  logic [1:0]         kind;
  logic               answers;
  logic [7:0]         depth_clamped;

  always_comb begin
    p_way   = rd_row[p_idx];
    kind    = p_way.bound[1:0];
    answers = (kind == tte_pkg::KIND_EXACT) ||
              (kind == tte_pkg::KIND_LOWER && p_way.value >= item.window_beta) ||
              (kind == tte_pkg::KIND_UPPER && p_way.value <= item.window_alpha);

    if (item.store_depth < 0) begin
      depth_clamped = 8'd0;
    end else if (item.store_depth > 16'sd255) begin
      depth_clamped = tte_pkg::DEPTH_MAX;
    end else begin
      depth_clamped = item.store_depth[7:0];
    end

    w_way.key_high = item.key_high;
    w_way.key_low  = item.key_low;
    w_way.move     = item.store_move;
    w_way.tag      = item.entry_tag;
    w_way.bound    = item.store_bound;
    w_way.depth    = depth_clamped;
    w_way.gen      = cur_gen;
    w_way.value    = item.store_value;

    new_row         = rd_row;
    new_row[victim] = w_way;

    res      = '0;
    store_we = 1'b0;
    wipe     = 1'b0;
    case (item.opcode)
      tte_pkg::OP_PROBE: begin
        if (enabled && p_found) begin
          if (answers) begin
            res.hit         = 1'b1;
            res.found_value = p_way.value;
            res.found_move  = p_way.move;
            res.found_depth = p_way.depth;
            res.found_bound = p_way.bound;
          end else begin
            res.partial = 1'b1;
          end
        end
      end
      tte_pkg::OP_STORE: begin
        if (enabled) begin
          store_we    = 1'b1;
          res.evicted = live[victim] && !key_eq[victim];
        end
      end
      tte_pkg::OP_NEW_SEARCH: begin
        wipe = (cur_gen == tte_pkg::GEN_LAST);
      end
      tte_pkg::OP_CLEAR: begin
        wipe = 1'b1;
      end
      default: begin
        wipe = 1'b0;
      end
    endcase
  end

  // memory port
  assign mem_we    = (state == tte_pkg::S_CLEAR) || (finish && store_we);
  assign mem_waddr = (state == tte_pkg::S_CLEAR) ? clr_idx : bucket;
  assign mem_wdata = (state == tte_pkg::S_CLEAR) ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bucket_mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= bucket_mem[rd_addr];
  end

  // controller
  always_comb begin
    state_next = state;
    case (state)
      tte_pkg::S_CLEAR: begin
        if (clr_idx == LAST_ROW) state_next = tte_pkg::S_IDLE;
      end
      tte_pkg::S_IDLE: begin
        if (in_valid) state_next = DIRECT ? tte_pkg::S_LOOKUP : tte_pkg::S_ADDR;
      end
      tte_pkg::S_ADDR: begin
        state_next = tte_pkg::S_LOOKUP;
      end
      tte_pkg::S_LOOKUP: begin
        if (finish) state_next = wipe ? tte_pkg::S_CLEAR : tte_pkg::S_IDLE;
      end
      default: begin
        state_next = tte_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tte_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // generation, sweep index and enable
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gen <= tte_pkg::GEN_FIRST;
      clr_idx <= '0;
      enabled <= 1'b1;
    end else begin
      if (cfg_write) begin
        enabled <= cfg_data;
      end
      if (state == tte_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (finish) begin
        clr_idx <= '0;
        if (wipe) begin
          cur_gen <= tte_pkg::GEN_FIRST;
        end else if (item.opcode == tte_pkg::OP_NEW_SEARCH) begin
          cur_gen <= cur_gen + 16'd1;
        end
      end
    end
  end

  // captured transaction and bucket address
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      quot <= quot_prod[FRAC +: HASH_W];
    end
    if (accept || state == tte_pkg::S_ADDR) begin
      bucket <= rd_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= res;
    end
  end

endmodule

// ===== test/tb_transposition_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_transposition_table_engine
// Self-checking bench for the transposition table engine. Every input
// transaction is run through a local model of the table at the edge where it
// is accepted. The bench queues the predicted response and compares it field
// by field with what leaves the out channel. It runs a short scripted part,
// then random phases with the table enabled and disabled. The in channel idles
// and the out channel stalls at random.
// ----------------------------------------------------------------------------
module tb_transposition_table_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WAYS    = tte_pkg::NUM_WAYS_DEF;
  localparam int NUM_BUCKETS = tte_pkg::NUM_BUCKETS_DEF;
  localparam int TOTAL_WAYS  = NUM_WAYS * NUM_BUCKETS;

  // handy keys for the scripted part
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_A    = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] KEY_C    = 64'h5A5A_5A5A_A5A5_A5A5;
  localparam logic [63:0] KEY_D    = 64'h0F0F_F0F0_3C3C_C3C3;
  localparam logic [63:0] KEY_E    = 64'h8000_0000_0000_0001;
  localparam logic [63:0] KEY_F    = 64'h7FFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] KEY_G    = 64'h1111_2222_3333_4444;

  // responses that can be read straight off the table contents
  localparam tte_pkg::out_item_t NO_RESULT   = '0;
  localparam tte_pkg::out_item_t HIT_ALL_MAX =
    tte_pkg::out_item_t'({1'b1, 1'b0, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0});
  localparam tte_pkg::out_item_t PARTIAL_HIT =
    tte_pkg::out_item_t'({1'b0, 1'b1, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0});

  typedef struct {
    int                 set_enable;   // -1 keeps the register, else value to write first
    tte_pkg::in_item_t  item;
    bit                 typed;        // response given in the row instead of predicted
    tte_pkg::out_item_t result;
  } script_row_t;

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [9:0]  hash;
    logic [7:0]  tag;
  } key_ref_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_data  = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tte_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tte_pkg::out_item_t out_data;

  // local copy of the table
  tte_pkg::way_t tt_way [TOTAL_WAYS];
  logic [15:0]   tt_gen;
  logic          tt_enabled;

  tte_pkg::out_item_t expected_responses [$];
  key_ref_t           key_pool [$];
  script_row_t        script [$];
  int                 hot_bucket [4];
  int                 mismatch_count = 0;
  int                 response_count = 0;
  int                 stall_left     = 0;
  bit                 quiet          = 1'b0;   // no idling on either side while set

  transposition_table_engine #(
    .NUM_WAYS    (NUM_WAYS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  // kill every way and restart the generation count
  function automatic void wipe_table();
    for (int i = 0; i < TOTAL_WAYS; i++) tt_way[i] = '0;
    tt_gen = tte_pkg::GEN_FIRST;
  endfunction

  // response of the table to one transaction, updating the local copy
  function automatic tte_pkg::out_item_t table_response(tte_pkg::in_item_t t);
    tte_pkg::out_item_t r;
    tte_pkg::way_t      w;
    tte_pkg::way_t      nw;
    int                 base;
    int                 victim;
    int                 best;
    int                 score;
    int                 d;
    logic [1:0]         kind;
    bit                 answers;
    bit                 live;
    bit                 done;
    r    = '0;
    done = 1'b0;
    base = (int'(t.hash_index) % NUM_BUCKETS) * NUM_WAYS;
    case (t.opcode)
      tte_pkg::OP_PROBE: begin
        if (tt_enabled) begin
          // first live way with matching tag and key decides
          for (int i = 0; i < NUM_WAYS; i++) begin
            w = tt_way[base + i];
            if (!done && w.gen == tt_gen && w.tag == t.entry_tag &&
                w.key_low == t.key_low && w.key_high == t.key_high) begin
              done    = 1'b1;
              kind    = w.bound[1:0];
              answers = (kind == tte_pkg::KIND_EXACT) ||
                        (kind == tte_pkg::KIND_LOWER && w.value >= t.window_beta) ||
                        (kind == tte_pkg::KIND_UPPER && w.value <= t.window_alpha);
              if (answers) begin
                r.hit         = 1'b1;
                r.found_value = w.value;
                r.found_move  = w.move;
                r.found_depth = w.depth;
                r.found_bound = w.bound;
              end else begin
                r.partial = 1'b1;
              end
            end
          end
        end
      end
      tte_pkg::OP_STORE: begin
        if (tt_enabled) begin
          victim = base;
          best   = -1;
          // same live key refreshes in place, else lowest score, earliest wins
          for (int i = 0; i < NUM_WAYS; i++) begin
            w    = tt_way[base + i];
            live = (w.gen == tt_gen);
            if (!done) begin
              if (live && w.key_low == t.key_low && w.key_high == t.key_high) begin
                victim = base + i;
                done   = 1'b1;
              end else begin
                score = live ? 1 + int'(w.depth) : 0;
                if (best < 0 || score < best) begin
                  victim = base + i;
                  best   = score;
                end
              end
            end
          end
          w = tt_way[victim];
          r.evicted = (w.gen == tt_gen) &&
                      (w.key_low != t.key_low || w.key_high != t.key_high);
          d = int'(t.store_depth);
          if (d < 0) d = 0;
          if (d > int'(tte_pkg::DEPTH_MAX)) d = int'(tte_pkg::DEPTH_MAX);
          nw.key_high = t.key_high;
          nw.key_low  = t.key_low;
          nw.move     = t.store_move;
          nw.tag      = t.entry_tag;
          nw.bound    = t.store_bound;
          nw.depth    = d[7:0];
          nw.gen      = tt_gen;
          nw.value    = t.store_value;
          tt_way[victim] = nw;
        end
      end
      tte_pkg::OP_NEW_SEARCH: begin
        // the last generation wraps through a full wipe
        if (tt_gen == tte_pkg::GEN_LAST) wipe_table();
        else tt_gen = tt_gen + 16'd1;
      end
      default: begin
        wipe_table();
      end
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus --

  function automatic tte_pkg::in_item_t mk(tte_pkg::opcode_t op,
                                           logic [63:0] klo, logic [63:0] khi,
                                           logic [9:0] hash, logic [7:0] tag,
                                           logic [15:0] alpha, logic [15:0] beta,
                                           logic [15:0] value, logic [15:0] move,
                                           logic [15:0] depth, logic [7:0] bound);
    tte_pkg::in_item_t t;
    t.opcode       = op;
    t.key_low      = klo;
    t.key_high     = khi;
    t.hash_index   = hash;
    t.entry_tag    = tag;
    t.window_alpha = alpha;
    t.window_beta  = beta;
    t.store_value  = value;
    t.store_move   = move;
    t.store_depth  = depth;
    t.store_bound  = bound;
    return t;
  endfunction

  task automatic add_row(input int set_enable, input tte_pkg::in_item_t t,
                         input bit typed, input tte_pkg::out_item_t result);
    script_row_t row;
    row.set_enable = set_enable;
    row.item       = t;
    row.typed      = typed;
    row.result     = result;
    script.push_back(row);
  endtask

  // random transaction; most probes and half the stores go to keys already stored,
  // and most new keys land in a few hot buckets so that ways get evicted
  function automatic tte_pkg::in_item_t make_random_item();
    tte_pkg::in_item_t t;
    key_ref_t          k;
    int                pick;
    int                sel;
    t.key_low      = {$urandom, $urandom};
    t.key_high     = {$urandom, $urandom};
    t.hash_index   = 10'($urandom_range(0, 1023));
    t.entry_tag    = 8'($urandom_range(0, 255));
    t.window_alpha = 16'($urandom_range(0, 65535));
    t.window_beta  = 16'($urandom_range(0, 65535));
    t.store_value  = 16'($urandom_range(0, 65535));
    t.store_move   = 16'($urandom_range(0, 65535));
    t.store_depth  = 16'($urandom_range(0, 65535));
    t.store_bound  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) t.opcode = tte_pkg::OP_PROBE;
    else if (pick < 88) t.opcode = tte_pkg::OP_STORE;
    else if (pick < 96) t.opcode = tte_pkg::OP_NEW_SEARCH;
    else t.opcode = tte_pkg::OP_CLEAR;

    if (t.opcode == tte_pkg::OP_PROBE) begin
      if (key_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        t.key_low    = k.key_low;
        t.key_high   = k.key_high;
        t.hash_index = k.hash;
        if ($urandom_range(0, 6) != 0) t.entry_tag = k.tag;
      end
      // windows near the stored values so both sides of each bound show up
      if ($urandom_range(0, 1) != 0) begin
        t.window_alpha = 16'($urandom_range(0, 400) - 200);
        t.window_beta  = 16'($urandom_range(0, 400) - 200);
      end
    end else if (t.opcode == tte_pkg::OP_STORE) begin
      if ($urandom_range(0, 1) != 0) t.store_value = 16'($urandom_range(0, 400) - 200);
      if ($urandom_range(0, 9) < 7) t.store_depth = 16'($urandom_range(0, 300) - 20);
      if (key_pool.size() != 0 && $urandom_range(0, 1) != 0) begin
        sel = $urandom_range(0, key_pool.size() - 1);
        t.key_low    = key_pool[sel].key_low;
        t.key_high   = key_pool[sel].key_high;
        t.hash_index = key_pool[sel].hash;
        if ($urandom_range(0, 9) < 7) t.entry_tag = key_pool[sel].tag;
        key_pool[sel].tag = t.entry_tag;
      end else begin
        if ($urandom_range(0, 3) != 0) t.hash_index = 10'(hot_bucket[$urandom_range(0, 3)]);
        k.key_low  = t.key_low;
        k.key_high = t.key_high;
        k.hash     = t.hash_index;
        k.tag      = t.entry_tag;
        key_pool.push_back(k);
        if (key_pool.size() > 24) key_pool.delete($urandom_range(0, 23));
      end
    end
    return t;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // ------------------------------------------------------------- handshake --

  // present one transaction, wait for it to be taken, queue its response
  task automatic send_transaction(input tte_pkg::in_item_t t, input int gap,
                                  input bit typed,
                                  input tte_pkg::out_item_t typed_result);
    tte_pkg::out_item_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // the local table moves with every accepted transaction, typed or not
    predicted = table_response(t);
    expected_responses.push_back(typed ? typed_result : predicted);
  endtask

  // hold off the in channel until every response is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input bit value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write  <= 1'b0;
    tt_enabled  = value;
  endtask

  // ---------------------------------------------------------------- checks --

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: response %0d, %s: got 0x%0h, expected 0x%0h",
             $time, response_count, what, got, want);
  endtask

  task automatic check_response(input tte_pkg::out_item_t got);
    tte_pkg::out_item_t want;
    if (expected_responses.size() == 0) begin
      report_mismatch("response with nothing outstanding", 32'(got), 32'd0);
    end else begin
      want = expected_responses.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.partial !== want.partial)
        report_mismatch("partial", 32'(got.partial), 32'(want.partial));
      if (got.found_value !== want.found_value)
        report_mismatch("found_value", 32'($unsigned(got.found_value)),
                        32'($unsigned(want.found_value)));
      if (got.found_move !== want.found_move)
        report_mismatch("found_move", 32'(got.found_move), 32'(want.found_move));
      if (got.found_depth !== want.found_depth)
        report_mismatch("found_depth", 32'(got.found_depth), 32'(want.found_depth));
      if (got.found_bound !== want.found_bound)
        report_mismatch("found_bound", 32'(got.found_bound), 32'(want.found_bound));
      if (got.evicted !== want.evicted)
        report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
    end
    response_count++;
  endtask

  // out channel: take a response, then stall for a freshly drawn count
  always @(posedge clk) begin
    logic stall_next;
    stall_next = out_stall;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      check_response(out_data);
      stall_left = quiet ? 0 : $urandom_range(0, 9);
      stall_next = (stall_left > 0);
    end else if (out_stall) begin
      if (stall_left > 0) stall_left--;
      stall_next = (stall_left > 0);
    end
    out_stall <= stall_next;
  end

  // ------------------------------------------------------------ main flow --

  initial begin
    int burst_left;
    int en;
    int n;
    burst_left = 0;
    tt_enabled = 1'b1;
    wipe_table();
    hot_bucket[0] = 0;
    hot_bucket[1] = 1023;
    hot_bucket[2] = $urandom_range(1, 1022);
    hot_bucket[3] = $urandom_range(1, 1022);

    // scripted part: extremes, each bound kind, eviction, refresh, aging,
    // clear and the disabled table
    add_row(1, mk(tte_pkg::OP_PROBE, KEY_ONES, KEY_ONES, 10'h3FF, 8'hFF,
                  16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 8'h0), 1'b1, NO_RESULT);
    // widest store, depth clamps to the top, bound byte all ones is exact
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_ONES, KEY_ONES, 10'h3FF, 8'hFF,
                   16'h0, 16'h0, 16'h7FFF, 16'hFFFF, 16'h7FFF, 8'hFF), 1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_ONES, KEY_ONES, 10'h3FF, 8'hFF,
                   16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 8'h0), 1'b1, HIT_ALL_MAX);
    // lowest value, negative depth clamps to zero, lower bound
    add_row(-1, mk(tte_pkg::OP_STORE, 64'h0, 64'h0, 10'h0, 8'h00, 16'h0, 16'h0,
                   16'h8000, 16'h0, 16'h8000, 8'h01), 1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, 64'h0, 64'h0, 10'h0, 8'h00, 16'h0, 16'h7FFF,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b1, PARTIAL_HIT);
    add_row(-1, mk(tte_pkg::OP_PROBE, 64'h0, 64'h0, 10'h0, 8'h00, 16'h0, 16'h8000,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // upper bound, answered only at or below alpha
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_A, KEY_B, 10'd5, 8'h01, 16'h0, 16'h0,
                   16'd100, 16'h1234, 16'd10, 8'h02), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_A, KEY_B, 10'd5, 8'h01, 16'd100, 16'd500,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_A, KEY_B, 10'd5, 8'h01, 16'd99, 16'd500,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // bound kind none never answers
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_B, KEY_A, 10'd5, 8'h02, 16'h0, 16'h0,
                   16'h0, 16'h4321, 16'h0, 8'hA4), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_B, KEY_A, 10'd5, 8'h02, 16'h7FFF, 16'h8000,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // wrong tag misses
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_A, KEY_B, 10'd5, 8'h09, 16'd100, 16'd500,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // fill the bucket, then the shallowest live way gets evicted
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_C, KEY_C, 10'd5, 8'h03, 16'h0, 16'h0,
                   16'd7, 16'h0007, 16'd300, 8'h03), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_D, KEY_D, 10'd5, 8'h04, 16'h0, 16'h0,
                   16'd8, 16'h0008, 16'd40, 8'h03), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_E, KEY_E, 10'd5, 8'h05, 16'h0, 16'h0,
                   16'd9, 16'h0009, 16'd1, 8'h03), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_B, KEY_A, 10'd5, 8'h02, 16'h7FFF, 16'h8000,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // same key under a new tag refreshes in place
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_A, KEY_B, 10'd5, 8'h07, 16'h0, 16'h0,
                   16'hFFFB, 16'hBEEF, 16'd20, 8'h03), 1'b0, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_A, KEY_B, 10'd5, 8'h07, 16'h0, 16'h0,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b0, NO_RESULT);
    // new search ages everything out
    add_row(-1, mk(tte_pkg::OP_NEW_SEARCH, KEY_ONES, 64'h0, 10'h3FF, 8'hFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF),
            1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_A, KEY_B, 10'd5, 8'h07, 16'h0, 16'h0,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_STORE, KEY_F, KEY_G, 10'd5, 8'h11, 16'h0, 16'h0,
                   16'd55, 16'h5555, 16'd5, 8'h03), 1'b0, NO_RESULT);
    // disabled table: stores write nothing, probes miss
    add_row(0, mk(tte_pkg::OP_STORE, KEY_G, KEY_F, 10'd6, 8'h22, 16'h0, 16'h0,
                  16'd66, 16'h6666, 16'd6, 8'h03), 1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_PROBE, KEY_F, KEY_G, 10'd5, 8'h11, 16'h0, 16'h0,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b1, NO_RESULT);
    add_row(1, mk(tte_pkg::OP_PROBE, KEY_G, KEY_F, 10'd6, 8'h22, 16'h0, 16'h0,
                  16'h0, 16'h0, 16'h0, 8'h0), 1'b1, NO_RESULT);
    add_row(-1, mk(tte_pkg::OP_CLEAR, 64'h0, KEY_ONES, 10'h0, 8'h00, 16'h0, 16'h0,
                   16'h0, 16'h0, 16'h0, 8'h0), 1'b1, NO_RESULT);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].set_enable >= 0) begin
        wait_drained();
        write_enable(script[k].set_enable[0]);
      end
      send_transaction(script[k].item, draw_gap(), script[k].typed, script[k].result);
    end

    // random phases, the enable register changes only between them
    for (int ph = 0; ph < 6; ph++) begin
      en = (ph == 1 || ph == 4) ? 0 : 1;
      n  = (en != 0) ? 130 : 40;
      wait_drained();
      write_enable(en[0]);
      for (int j = 0; j < n; j++) begin
        // occasional bursts with no idling on either side
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 25);
        quiet = (burst_left > 0);
        // now and then let the pipe run dry before the next transaction
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_transaction(make_random_item(), draw_gap(), 1'b0, NO_RESULT);
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
